/* sv/rgba_source_over_blend_core_defines.svh */
// assertion macros shared by the blend core rtl
`ifndef RGBA_SOURCE_OVER_BLEND_CORE_DEFINES_SVH
`define RGBA_SOURCE_OVER_BLEND_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RSOB_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define RSOB_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/rsob_pkg.sv */
// types, constants and helpers for the rgba source-over blend core
`default_nettype none

package rsob_pkg;

    localparam logic [7:0] FULL_ALPHA = 8'hFF;
    localparam int CHANNELS = 3;
    localparam int NUM_W = 17;
    localparam int QUO_W = 8;
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES = QUO_W / DIV_BITS_PER_STAGE;
    localparam int FRONT_STAGES = 4;
    localparam int PIPE_DEPTH = FRONT_STAGES + DIV_STAGES + 1;

    typedef struct packed {
        logic [7:0] src_red;
        logic [7:0] src_green;
        logic [7:0] src_blue;
        logic [7:0] src_alpha;
        logic [7:0] dst_red;
        logic [7:0] dst_green;
        logic [7:0] dst_blue;
        logic [7:0] dst_alpha;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } t_pix_out;

    // floor(x / 255), exact for x up to 255 * 255
    function automatic logic [7:0] f_div255(input logic [15:0] x);
        logic [16:0] t;
        t = 17'(x) + 17'(x[15:8]) + 17'd1;
        return t[15:8];
    endfunction

endpackage

`default_nettype wire

/* sv/rsob_div.sv */
// pipelined restoring divider, two quotient bits per stage, saturating at 255
`default_nettype none

module rsob_div
    import rsob_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic [DIV_STAGES-1:0] i_en,
    input  wire logic [NUM_W-1:0]      i_num,
    input  wire logic [7:0]            i_den,
    output logic      [QUO_W-1:0]      o_quo
);

    logic [NUM_W-1:0] r_rem [DIV_STAGES];
    logic [7:0]       r_den [DIV_STAGES];
    logic [QUO_W-1:0] r_quo [DIV_STAGES];
    logic             r_sat [DIV_STAGES];

    logic [NUM_W-1:0] n_rem [DIV_STAGES];
    logic [7:0]       n_den [DIV_STAGES];
    logic [QUO_W-1:0] n_quo [DIV_STAGES];
    logic             n_sat [DIV_STAGES];

    always_comb begin
        logic [NUM_W-1:0] rem;
        logic [NUM_W-1:0] trial;
        logic [QUO_W-1:0] quo;
        int               b;
        for (int j = 0; j < DIV_STAGES; j++) begin
            if (j == 0) begin
                rem        = i_num;
                quo        = '0;
                n_den[j]   = i_den;
                n_sat[j]   = i_num >= NUM_W'({i_den, 8'h00});
            end else begin
                rem        = r_rem[(j == 0) ? 0 : j - 1];
                quo        = r_quo[(j == 0) ? 0 : j - 1];
                n_den[j]   = r_den[(j == 0) ? 0 : j - 1];
                n_sat[j]   = r_sat[(j == 0) ? 0 : j - 1];
            end
            for (int s = 0; s < DIV_BITS_PER_STAGE; s++) begin
                b     = QUO_W - 1 - j * DIV_BITS_PER_STAGE - s;
                trial = NUM_W'(n_den[j]) << b;
                if (rem >= trial) begin
                    rem = rem - trial;
                    quo = quo | (QUO_W'(1) << b);
                end
            end
            n_rem[j] = rem;
            n_quo[j] = quo;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < DIV_STAGES; j++) begin
            if (i_en[j]) begin
                r_rem[j] <= n_rem[j];
                r_den[j] <= n_den[j];
                r_quo[j] <= n_quo[j];
                r_sat[j] <= n_sat[j];
            end
        end
    end

    assign o_quo = r_sat[DIV_STAGES-1] ? FULL_ALPHA : r_quo[DIV_STAGES-1];

endmodule

`default_nettype wire

/* sv/rgba_source_over_blend_core.sv */
// top level of the rgba source-over blend core
// Blends a straight-alpha rgba8 source pixel over a destination pixel. A fully
// transparent source passes the destination through, a fully opaque one copies
// the source colour with alpha 255, anything else gets the source-over alpha and
// colours divided by the new alpha. One item is taken every cycle while the
// output is not stalled, and each passes through four stages of multiplies and
// divide-by-255, four stages of the two-bit-per-stage colour divider and one
// output register. A stall on the output fills empty stages first, then holds
// the input off.
`default_nettype none

module rgba_source_over_blend_core
    import rsob_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_pix_in  i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_pix_out      o_out_data
);

`include "rgba_source_over_blend_core_defines.svh"

    localparam int ST_DIV = FRONT_STAGES;
    localparam int ST_OUT = PIPE_DEPTH - 1;

    logic [PIPE_DEPTH-1:0] r_vld, n_vld;
    logic [PIPE_DEPTH:0]   w_rdy;
    logic [PIPE_DEPTH-1:0] w_vin;

    logic [7:0] w_src [CHANNELS];
    logic [7:0] w_dst [CHANNELS];

    logic [15:0] r1_ssa [CHANNELS];
    logic [15:0] r1_dda [CHANNELS];
    logic [15:0] r1_pa;
    logic [7:0]  r1_sa, r1_da, r1_inv;
    logic        r1_byp;
    t_pix_out    r1_bpix;

    logic [23:0] r2_w   [CHANNELS];
    logic [15:0] r2_ssa [CHANNELS];
    logic [7:0]  r2_oa;
    logic        r2_byp;
    t_pix_out    r2_bpix;
    logic [8:0]  w_oa;

    logic [23:0] r3_w   [CHANNELS];
    logic [15:0] r3_qe  [CHANNELS];
    logic [15:0] r3_ssa [CHANNELS];
    logic [7:0]  r3_oa;
    logic        r3_byp;
    t_pix_out    r3_bpix;

    logic [NUM_W-1:0] r4_num [CHANNELS];
    logic [7:0]       r4_oa;
    logic             r4_byp;
    t_pix_out         r4_bpix;

    logic [7:0]  r_doa   [DIV_STAGES];
    logic        r_dbyp  [DIV_STAGES];
    t_pix_out    r_dbpix [DIV_STAGES];

    logic [QUO_W-1:0] w_quo [CHANNELS];
    t_pix_out         r_out;

    // stage handshake: a stage loads when it is empty or its successor moves
    assign w_vin = {r_vld[PIPE_DEPTH-2:0], i_in_valid};

    always_comb begin
        w_rdy[PIPE_DEPTH] = i_out_ready;
        for (int k = PIPE_DEPTH - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
        n_vld = r_vld;
        for (int k = 0; k < PIPE_DEPTH; k++) begin
            if (w_rdy[k]) begin
                n_vld[k] = w_vin[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = w_rdy[0];
    assign o_out_valid = r_vld[ST_OUT];
    assign o_out_data  = r_out;

    assign w_src[0] = i_in_data.src_red;
    assign w_src[1] = i_in_data.src_green;
    assign w_src[2] = i_in_data.src_blue;
    assign w_dst[0] = i_in_data.dst_red;
    assign w_dst[1] = i_in_data.dst_green;
    assign w_dst[2] = i_in_data.dst_blue;

    // stage 1: products and bypass pixel
    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r1_ssa[c] <= 16'(w_src[c]) * 16'(i_in_data.src_alpha);
                r1_dda[c] <= 16'(w_dst[c]) * 16'(i_in_data.dst_alpha);
            end
            r1_pa  <= 16'(i_in_data.src_alpha) * 16'(i_in_data.dst_alpha);
            r1_sa  <= i_in_data.src_alpha;
            r1_da  <= i_in_data.dst_alpha;
            r1_inv <= FULL_ALPHA - i_in_data.src_alpha;
            r1_byp <= (i_in_data.src_alpha == 8'h00) || (i_in_data.src_alpha == FULL_ALPHA);
            if (i_in_data.src_alpha == 8'h00) begin
                r1_bpix <= '{out_red: i_in_data.dst_red, out_green: i_in_data.dst_green,
                             out_blue: i_in_data.dst_blue, out_alpha: i_in_data.dst_alpha};
            end else begin
                r1_bpix <= '{out_red: i_in_data.src_red, out_green: i_in_data.src_green,
                             out_blue: i_in_data.src_blue, out_alpha: FULL_ALPHA};
            end
        end
    end

    // stage 2: destination weight and output alpha
    assign w_oa = 9'(r1_sa) + 9'(r1_da) - 9'(f_div255(r1_pa));

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r2_w[c]   <= 24'(r1_dda[c]) * 24'(r1_inv);
                r2_ssa[c] <= r1_ssa[c];
            end
            r2_oa   <= w_oa[7:0];
            r2_byp  <= r1_byp;
            r2_bpix <= r1_bpix;
        end
    end

    // stage 3: estimate of weight / 255, low by at most one
    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r3_qe[c]  <= 16'((25'(r2_w[c]) + 25'(r2_w[c] >> 8) + 25'(r2_w[c] >> 16)) >> 8);
                r3_w[c]   <= r2_w[c];
                r3_ssa[c] <= r2_ssa[c];
            end
            r3_oa   <= r2_oa;
            r3_byp  <= r2_byp;
            r3_bpix <= r2_bpix;
        end
    end

    // stage 4: correct the estimate and form the numerator
    always_ff @(posedge i_clk) begin
        logic [24:0] rem;
        logic [16:0] fix;
        if (w_rdy[3]) begin
            for (int c = 0; c < CHANNELS; c++) begin
                rem = 25'(r3_w[c]) + 25'(r3_qe[c]) - 25'({r3_qe[c], 8'h00});
                fix = 17'(r3_qe[c]) + 17'(rem >= 25'(FULL_ALPHA));
                r4_num[c] <= 17'(r3_ssa[c]) + fix;
            end
            r4_oa   <= r3_oa;
            r4_byp  <= r3_byp;
            r4_bpix <= r3_bpix;
        end
    end

    // divider stages
    for (genvar c = 0; c < CHANNELS; c++) begin : g_div
        rsob_div u_div (
            .i_clk (i_clk),
            .i_en  (w_rdy[ST_DIV +: DIV_STAGES]),
            .i_num (r4_num[c]),
            .i_den (r4_oa),
            .o_quo (w_quo[c])
        );
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < DIV_STAGES; j++) begin
            if (w_rdy[ST_DIV + j]) begin
                if (j == 0) begin
                    r_doa[j]   <= r4_oa;
                    r_dbyp[j]  <= r4_byp;
                    r_dbpix[j] <= r4_bpix;
                end else begin
                    r_doa[j]   <= r_doa[(j == 0) ? 0 : j - 1];
                    r_dbyp[j]  <= r_dbyp[(j == 0) ? 0 : j - 1];
                    r_dbpix[j] <= r_dbpix[(j == 0) ? 0 : j - 1];
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_rdy[ST_OUT]) begin
            if (r_dbyp[DIV_STAGES-1]) begin
                r_out <= r_dbpix[DIV_STAGES-1];
            end else begin
                r_out <= '{out_red: w_quo[0], out_green: w_quo[1], out_blue: w_quo[2],
                           out_alpha: r_doa[DIV_STAGES-1]};
            end
        end
    end

    `RSOB_ASSERT_IMP(a_full_when_blocked, i_clk, i_rst_n, !o_in_ready, &r_vld, "input held off with an empty stage")
    `RSOB_ASSERT_NXT(a_occupancy_up, i_clk, i_rst_n, (i_in_valid && o_in_ready) && !(o_out_valid && i_out_ready), $countones(r_vld) == $past($countones(r_vld)) + 1, "item lost on entry")
    `RSOB_ASSERT_NXT(a_occupancy_down, i_clk, i_rst_n, !(i_in_valid && o_in_ready) && (o_out_valid && i_out_ready), $countones(r_vld) + 1 == $past($countones(r_vld)), "item repeated after delivery")
    `RSOB_ASSERT_IMP(a_alpha_nonzero, i_clk, i_rst_n, r_vld[1] && !r2_byp, r2_oa != 8'h00, "zero divisor for a partial alpha item")

endmodule

`default_nettype wire

/* sim/tb_rgba_source_over_blend_core.sv */
// testbench for the rgba source-over blend core: directed and random pixels, checked in order
`timescale 1ns / 1ps

module tb_rgba_source_over_blend_core
    import rsob_pkg::*;
();

    localparam int unsigned ALPHA_MAX = 255;
    localparam int N_RANDOM = 1270;
    localparam int LONG_HOLD = 300;
    localparam int HOLD_BURST = 60;
    localparam int DRAIN_CYCLES = 20;
    localparam longint CYCLE_LIMIT = 400000;

    class blend_scoreboard;
        t_pix_out expected_q[$];
        int unsigned errors;

        static function logic [7:0] blend_colour(int unsigned s, sa, d, da, oa);
            int unsigned num;
            int unsigned q;
            num = s * sa + (d * da * (ALPHA_MAX - sa)) / ALPHA_MAX;
            q = num / oa;
            if (q > ALPHA_MAX) q = ALPHA_MAX;
            return q[7:0];
        endfunction

        static function t_pix_out blend_pixel(t_pix_in p);
            t_pix_out r;
            int unsigned sa;
            int unsigned da;
            int unsigned oa;
            sa = 32'(p.src_alpha);
            da = 32'(p.dst_alpha);
            if (sa == 0) begin
                r = {p.dst_red, p.dst_green, p.dst_blue, p.dst_alpha};
            end else if (sa == ALPHA_MAX) begin
                r = {p.src_red, p.src_green, p.src_blue, FULL_ALPHA};
            end else begin
                oa = sa + da - (sa * da) / ALPHA_MAX;
                r.out_red   = blend_colour(32'(p.src_red), sa, 32'(p.dst_red), da, oa);
                r.out_green = blend_colour(32'(p.src_green), sa, 32'(p.dst_green), da, oa);
                r.out_blue  = blend_colour(32'(p.src_blue), sa, 32'(p.dst_blue), da, oa);
                r.out_alpha = oa[7:0];
            end
            return r;
        endfunction

        function void note_pixel(t_pix_in p);
            expected_q.push_back(blend_pixel(p));
        endfunction

        function void compare_field(string name, logic [7:0] want_v, logic [7:0] got_v);
            if (got_v !== want_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want_v, got_v);
            end
        endfunction

        function void check_pixel(t_pix_out got);
            t_pix_out want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result with no item pending, expected none, actual %h",
                         $time, got);
                return;
            end
            want = expected_q.pop_front();
            compare_field("out_red", want.out_red, got.out_red);
            compare_field("out_green", want.out_green, got.out_green);
            compare_field("out_blue", want.out_blue, got.out_blue);
            compare_field("out_alpha", want.out_alpha, got.out_alpha);
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction
    endclass

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_ready;
    t_pix_in  i_in_data;
    logic     o_out_valid;
    logic     i_out_ready;
    t_pix_out o_out_data;

    blend_scoreboard board = new();
    longint cycle_count = 0;
    bit long_hold_req = 1'b0;
    bit send_quiet = 1'b0;

    rgba_source_over_blend_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_rgba_source_over_blend_core failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) board.check_pixel(o_out_data);
    end

    function automatic t_pix_in make_pixel(logic [7:0] sr, sg, sb, sa, dr, dg, db, da);
        return {sr, sg, sb, sa, dr, dg, db, da};
    endfunction

    function automatic t_pix_in rand_pixel();
        t_pix_in p;
        int unsigned pick;
        p = {$urandom, $urandom};
        pick = $urandom_range(0, 9);
        if (pick == 0) p.src_alpha = 8'd0;
        else if (pick == 1) p.src_alpha = FULL_ALPHA;
        pick = $urandom_range(0, 9);
        if (pick == 0) p.dst_alpha = 8'd0;
        else if (pick == 1) p.dst_alpha = FULL_ALPHA;
        return p;
    endfunction

    function automatic int unsigned sender_gap();
        if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
        return send_quiet ? 0 : $urandom_range(0, 16);
    endfunction

    task automatic offer_pixel(input t_pix_in p, input int unsigned gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= p;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_pixel(p);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge i_clk);
    endtask

    // receiver: random stalls per item, quiet stretches, and one long hold on request
    initial begin
        int unsigned stall;
        bit quiet;
        quiet = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (long_hold_req) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_req = 1'b0;
            end else begin
                if ($urandom_range(0, 31) == 0) quiet = !quiet;
                stall = quiet ? 0 : $urandom_range(0, 16);
                if (stall > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid && !long_hold_req);
        end
    end

    initial begin
        t_pix_in directed_px[$];
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        i_out_ready <= 1'b0;

        // transparent source
        directed_px.push_back(make_pixel(10, 20, 30, 0, 40, 50, 60, 70));
        directed_px.push_back(make_pixel(255, 255, 255, 0, 255, 255, 255, 255));
        directed_px.push_back(make_pixel(0, 0, 0, 0, 0, 0, 0, 0));
        // opaque source
        directed_px.push_back(make_pixel(1, 2, 3, 255, 200, 100, 50, 0));
        directed_px.push_back(make_pixel(255, 255, 255, 255, 0, 0, 0, 0));
        directed_px.push_back(make_pixel(0, 0, 0, 255, 255, 255, 255, 255));
        // partial alpha, edges of both alphas
        directed_px.push_back(make_pixel(255, 255, 255, 1, 0, 0, 0, 0));
        directed_px.push_back(make_pixel(255, 0, 128, 1, 255, 255, 255, 255));
        directed_px.push_back(make_pixel(255, 255, 255, 254, 0, 0, 0, 255));
        directed_px.push_back(make_pixel(0, 0, 0, 254, 255, 255, 255, 255));
        directed_px.push_back(make_pixel(255, 255, 255, 128, 255, 255, 255, 0));
        directed_px.push_back(make_pixel(255, 255, 255, 128, 255, 255, 255, 255));
        directed_px.push_back(make_pixel(0, 0, 0, 128, 0, 0, 0, 128));
        directed_px.push_back(make_pixel(255, 0, 255, 127, 0, 255, 0, 128));
        directed_px.push_back(make_pixel(170, 85, 170, 85, 85, 170, 85, 170));
        directed_px.push_back(make_pixel(85, 170, 85, 170, 170, 85, 170, 85));
        directed_px.push_back(make_pixel(255, 255, 255, 1, 255, 255, 255, 1));
        directed_px.push_back(make_pixel(0, 0, 0, 1, 255, 255, 255, 254));
        directed_px.push_back(make_pixel(128, 64, 32, 200, 16, 8, 4, 2));
        directed_px.push_back(make_pixel(255, 255, 255, 254, 255, 255, 255, 254));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_px[k]) offer_pixel(directed_px[k], sender_gap());
        drain_results();

        for (int k = 0; k < N_RANDOM; k++) begin
            if (k == N_RANDOM / 3) begin
                // back-to-back items while the output is held off
                long_hold_req = 1'b1;
                for (int j = 0; j < HOLD_BURST; j++) offer_pixel(rand_pixel(), 0);
            end
            if (k == 2 * N_RANDOM / 3) drain_results();
            offer_pixel(rand_pixel(), sender_gap());
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.outstanding() == 0) begin
            $display("tb_rgba_source_over_blend_core passed");
        end else begin
            $display("tb_rgba_source_over_blend_core failed");
        end
        $finish;
    end

endmodule
